>>> sv/alawpf_pkg.sv
package alawpf_pkg;

	// default sizes
	localparam int RING_DEPTH_DEF  = 1024;
	localparam int SAMPLE_RATE_DEF = 8000;
	localparam int TICKS_PER_SEC   = 64;

	// field widths
	localparam int MODE_W = 2;
	localparam int BYTE_W = 8;
	localparam int TONE_W = 13;
	localparam int SAMP_W = 16;
	localparam int CLICK_W = 12;
	localparam int HOLD_W = 8;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W = 2;

	// item kinds
	localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EDGE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SPEAKER_ENABLED  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TONE_HZ    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_HOLD_TICKS = 2'd2;

	// register reset values
	localparam logic               SPEAKER_RST = 1'b1;
	localparam logic [CLICK_W-1:0] CLICK_RST   = 12'd1000;
	localparam logic [HOLD_W-1:0]  HOLD_RST    = 8'd2;

	// a-law and tone constants
	localparam logic [BYTE_W-1:0] ALAW_XOR  = 8'h55;
	localparam logic [BYTE_W-1:0] ALAW_SEG  = 8'h70;
	localparam logic [BYTE_W-1:0] ALAW_LOW  = 8'h0f;
	localparam logic [BYTE_W-1:0] ALAW_BASE = 8'h10;
	localparam logic [BYTE_W-1:0] ALAW_SIGN = 8'h80;
	localparam logic [SAMP_W-1:0] TONE_HIGH = 16'h2000;
	localparam logic [SAMP_W-1:0] TONE_LOW  = 16'he000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] alaw_byte;
		logic              buzzer_active;
		logic [TONE_W-1:0] tone_hz;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMP_W-1:0] sample;
		logic                     sample_present;
	} out_item_t;

	typedef struct packed {
		logic               speaker_enabled;
		logic [CLICK_W-1:0] click_tone_hz;
		logic [HOLD_W-1:0]  click_hold_ticks;
	} cfg_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [MODE_W-1:0] kind;
		logic [SAMP_W-1:0] pcm;
		logic              active;
		logic [TONE_W-1:0] tone;
	} cmd_t;

	// expand, sign and scale by 8
	function automatic logic [SAMP_W-1:0] alaw_to_pcm(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] d;
		logic [2:0]        seg;
		logic [2:0]        sh;
		logic [4:0]        m5;
		logic [SAMP_W-1:0] mag;
		d = b ^ ALAW_XOR;
		seg = 3'((d & ALAW_SEG) >> 4);
		if (seg != 3'd0) begin
			m5 = 5'((ALAW_BASE | (d & ALAW_LOW)));
			sh = seg - 3'd1;
		end else begin
			m5 = 5'(d & ALAW_LOW);
			sh = 3'd0;
		end
		mag = SAMP_W'({m5, 1'b1}) << sh;
		mag = mag << 3;
		if ((d & ALAW_SIGN) != '0)
			return SAMP_W'(0) - mag;
		return mag;
	endfunction

endpackage

>>> sv/alawpf_ram.sv
module alawpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/alawpf_front.sv
module alawpf_front import alawpf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_item,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_pop
);

	// two-entry queue between front and back
	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cls;

	always_comb begin
		cls.kind   = in_item.mode;
		cls.pcm    = alaw_to_pcm(in_item.alaw_byte);
		cls.active = in_item.buzzer_active;
		cls.tone   = in_item.tone_hz;
	end

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop)
				rd_ptr_q <= !rd_ptr_q;
			unique case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/alawpf_back.sv
module alawpf_back import alawpf_pkg::*; #(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int PW  = $clog2(RING_DEPTH);
	localparam int QW  = $clog2(SAMPLE_RATE + 1);
	localparam int DW  = TONE_W + 1;
	localparam int RW  = ((QW > DW) ? QW : DW) + 1;
	localparam int NS  = SAMPLE_RATE / TICKS_PER_SEC;
	localparam int CW  = $clog2(NS);
	localparam int DCW = $clog2(QW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_TONE = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	logic [1:0]        state_q;
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     rp_q;
	logic [QW-1:0]     phase_q;
	logic [HOLD_W-1:0] hold_q;
	logic [QW-1:0]     half_q;
	logic [QW-1:0]     div_q;
	logic [RW-1:0]     rem_q;
	logic [DW-1:0]     dvs_q;
	logic [DCW-1:0]    div_cnt_q;
	logic [CW-1:0]     samp_cnt_q;
	logic              out_valid_q;
	logic [SAMP_W-1:0] sample_q;
	logic              present_q;

	logic [PW-1:0]     wp_nx;
	logic [PW-1:0]     rp_nx;
	logic              ring_we;
	logic [SAMP_W-1:0] ring_wd;
	logic [SAMP_W-1:0] ring_rd;
	logic              rd_adv;
	logic              out_free;
	logic              gate;
	logic [TONE_W-1:0] tone_eff;
	logic [RW-1:0]     trial;
	logic              qbit;
	logic [QW-1:0]     quot;
	logic [QW:0]       phase_inc;
	logic              phase_wrap;
	logic              out_load;
	logic [SAMP_W-1:0] out_sample;
	logic              out_present;

	alawpf_ram #(
		.WIDTH(SAMP_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(wp_q),
		.wdata(ring_wd),
		.raddr(rp_q),
		.rdata(ring_rd)
	);

	assign wp_nx    = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + PW'(1);
	assign rp_nx    = (rp_q == PW'(RING_DEPTH - 1)) ? '0 : rp_q + PW'(1);
	assign out_free = !out_valid_q || !out_stall;
	assign gate     = cmd.active || (hold_q != '0);

	always_comb begin
		tone_eff = (cmd.tone != '0) ? cmd.tone : TONE_W'(cfg.click_tone_hz);
		if (tone_eff == '0)
			tone_eff = TONE_W'(1);
	end

	// one quotient bit per cycle
	assign trial = {rem_q[RW-2:0], div_q[QW-1]};
	assign qbit  = (trial >= RW'(dvs_q));
	assign quot  = {div_q[QW-2:0], qbit};

	assign phase_inc  = {1'b0, phase_q} + (QW+1)'(1);
	assign phase_wrap = (phase_inc >= {half_q, 1'b0});

	always_comb begin
		ring_we     = 1'b0;
		ring_wd     = '0;
		cmd_pop     = 1'b0;
		rd_adv      = 1'b0;
		out_load    = 1'b0;
		out_sample  = '0;
		out_present = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						MODE_PUSH: begin
							cmd_pop = 1'b1;
							ring_we = 1'b1;
							ring_wd = cmd.pcm;
						end
						MODE_TICK: begin
							cmd_pop = 1'b1;
							ring_we = !gate;
						end
						MODE_EDGE: cmd_pop = 1'b1;
						MODE_READ: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								if (rp_q == wp_q)
									out_load = 1'b1;
								else
									rd_adv = 1'b1;
							end
						end
						default: cmd_pop = 1'b1;
					endcase
				end
			end
			ST_TONE: begin
				ring_we = 1'b1;
				ring_wd = (phase_q < half_q) ? TONE_HIGH : TONE_LOW;
			end
			ST_READ: begin
				out_load    = 1'b1;
				out_sample  = cfg.speaker_enabled ? ring_rd : '0;
				out_present = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_q  <= out_sample;
			present_q <= out_present;
		end
		if (state_q == ST_IDLE && cmd_valid && cmd.kind == MODE_TICK) begin
			dvs_q <= {tone_eff, 1'b0};
			div_q <= QW'(SAMPLE_RATE);
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_q <= quot;
			rem_q <= qbit ? trial - RW'(dvs_q) : trial;
		end
		if (state_q == ST_DIV && div_cnt_q == '0)
			half_q <= (quot == '0) ? QW'(1) : quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			phase_q     <= '0;
			hold_q      <= '0;
			div_cnt_q   <= '0;
			samp_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ring_we) begin
				wp_q <= wp_nx;
				if (wp_nx == rp_q)
					rp_q <= rp_nx;
			end else if (rd_adv) begin
				rp_q <= rp_nx;
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd.kind == MODE_TICK) begin
						if (hold_q != '0)
							hold_q <= hold_q - HOLD_W'(1);
						if (gate) begin
							state_q   <= ST_DIV;
							div_cnt_q <= DCW'(QW - 1);
						end else begin
							phase_q <= '0;
						end
					end else if (cmd_valid && cmd.kind == MODE_EDGE) begin
						hold_q <= cfg.click_hold_ticks;
					end else if (rd_adv) begin
						state_q <= ST_READ;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q    <= ST_TONE;
						samp_cnt_q <= CW'(NS - 1);
					end else begin
						div_cnt_q <= div_cnt_q - DCW'(1);
					end
				end
				ST_TONE: begin
					phase_q <= phase_wrap ? '0 : phase_inc[QW-1:0];
					if (samp_cnt_q == '0)
						state_q <= ST_IDLE;
					else
						samp_cnt_q <= samp_cnt_q - CW'(1);
				end
				ST_READ: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid               = out_valid_q;
	assign out_item.sample         = sample_q;
	assign out_item.sample_present = present_q;

	// a popped sample always lands in the output register
	a_read_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> out_valid_q)
		else $error("read did not load output register");

	// never overwrite a result that is still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_valid_q) |-> !out_stall)
		else $error("result overwritten while stalled");

	// the divider hands over to the tone writer
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == '0) |=> (state_q == ST_TONE && half_q != '0))
		else $error("divider did not finish into tone state");

	// pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(wp_q) < RING_DEPTH) && (32'(rp_q) < RING_DEPTH))
		else $error("ring pointer out of range");

	// a command is never popped while the queue is empty
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

endmodule

>>> sv/alaw_playback_fifo_with_buzzer.sv
// channel   direction  handshake              payload
// in        to block   in_valid / in_stall    in_item   (mode, alaw_byte, buzzer_active, tone_hz)
// out       from block out_valid / out_stall  out_item  (sample, sample_present)
// cfg       to block   cfg_we                 cfg_index, cfg_data
//
// push and rising edge are handled in the back end's idle state; a read of a non-empty ring goes
// through the read state (ring memory read port), a read of an empty ring loads the result directly
// a buzzer tick with the gate open runs the half-period divider, one quotient bit per cycle,
// then writes SAMPLE_RATE/64 tone samples to the ring; a closed gate writes one silent sample
// the front queue holds two items, so the input stalls only when both are waiting
// reset clears pointers, phase, hold count and the queue; ring contents are left as they are
module alaw_playback_fifo_with_buzzer import alawpf_pkg::*; #(
	parameter int RING_DEPTH  = RING_DEPTH_DEF,
	parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	cfg_t cfg_q;

	// front to back queue interface
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// register writes, an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speaker_enabled  <= SPEAKER_RST;
			cfg_q.click_tone_hz    <= CLICK_RST;
			cfg_q.click_hold_ticks <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPEAKER_ENABLED:  cfg_q.speaker_enabled  <= cfg_data[0];
				CFG_CLICK_TONE_HZ:    cfg_q.click_tone_hz    <= cfg_data[CLICK_W-1:0];
				CFG_CLICK_HOLD_TICKS: cfg_q.click_hold_ticks <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// front end: takes items, expands a-law bytes, queues commands
	alawpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	// back end: ring, tone generator and result register
	alawpf_back #(
		.RING_DEPTH (RING_DEPTH),
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

>>> sim/tb_alaw_playback_fifo_with_buzzer.sv
`timescale 1ns / 1ps

module tb_alaw_playback_fifo_with_buzzer;
	import alawpf_pkg::*;

	localparam int RING_DEPTH    = RING_DEPTH_DEF;
	localparam int SAMPLE_RATE   = SAMPLE_RATE_DEF;
	localparam int PHASE_ITEMS   = 140;
	// enough for two queued ticks plus one in the back end to finish
	localparam int SETTLE_CYCLES = 600;
	localparam int LONG_HOLD     = 300;
	// cycles without any item moving before the run is declared hung
	localparam int STUCK_LIMIT   = 5000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	alaw_playback_fifo_with_buzzer #(
		.RING_DEPTH (RING_DEPTH),
		.SAMPLE_RATE(SAMPLE_RATE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// items waiting to be offered, and popped samples the block owes us
	in_item_t  queued_items[$];
	out_item_t expected_samples[$];

	// shadow of the playback state
	logic [SAMP_W-1:0] ring_mem [RING_DEPTH];
	int rd_ptr    = 0;
	int wr_ptr    = 0;
	int tone_pos  = 0;
	int hold_left = 0;

	// shadow of the registers, reset values
	logic spk_en     = SPEAKER_RST;
	int   click_hz   = CLICK_RST;
	int   click_hold = HOLD_RST;

	// run statistics
	int n_push, n_tick, n_edge, n_read, n_empty, n_muted, n_dropped;
	int n_checked, n_settings, errors;

	// sequencing knobs set from the stimulus thread at the falling edge
	bit calm_run    = 1'b0;
	int hold_ticket = 0;

	// ---------------------------------------------------------------------------------------
	// playback predictor
	// ---------------------------------------------------------------------------------------

	function automatic int ring_next(int p);
		return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
	endfunction

	// full ring drops its oldest sample so that it never looks empty
	function automatic void ring_put(logic [SAMP_W-1:0] s);
		int n;
		n = ring_next(wr_ptr);
		if (n == rd_ptr) begin
			rd_ptr = ring_next(rd_ptr);
			n_dropped++;
		end
		ring_mem[wr_ptr] = s;
		wr_ptr = n;
	endfunction

	// segment/mantissa expansion, sign, then scale by 8
	function automatic logic [SAMP_W-1:0] expand_alaw(logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] d;
		int seg;
		int base;
		int mag;
		d = b ^ ALAW_XOR;
		seg = int'((d & ALAW_SEG) >> 4);
		base = 0;
		if (seg != 0) begin
			base = int'(ALAW_BASE);
			seg--;
		end
		mag = (((base + int'(d & ALAW_LOW)) << 1) + 1) << seg;
		mag = mag * 8;
		if ((d & ALAW_SIGN) != '0)
			return SAMP_W'(-mag);
		return SAMP_W'(mag);
	endfunction

	function automatic void buzzer_tick(logic active, logic [TONE_W-1:0] tone_req);
		bit gate;
		int tone;
		int half;
		gate = active || (hold_left != 0);
		if (hold_left != 0)
			hold_left--;
		// closed gate: a single silent sample and the phase starts over
		if (!gate) begin
			ring_put('0);
			tone_pos = 0;
			return;
		end
		tone = (tone_req != '0) ? int'(tone_req) : click_hz;
		if (tone == 0)
			tone = 1;
		half = SAMPLE_RATE / (2 * tone);
		if (half < 1)
			half = 1;
		for (int i = 0; i < SAMPLE_RATE / TICKS_PER_SEC; i++) begin
			// a phase left over from a longer period counts as the low half
			ring_put((tone_pos < half) ? TONE_HIGH : TONE_LOW);
			tone_pos++;
			if (tone_pos >= 2 * half)
				tone_pos = 0;
		end
	endfunction

	function automatic void playback_step(in_item_t it);
		out_item_t res;
		case (it.mode)
			MODE_PUSH: begin
				ring_put(expand_alaw(it.alaw_byte));
				n_push++;
			end
			MODE_TICK: begin
				buzzer_tick(it.buzzer_active, it.tone_hz);
				n_tick++;
			end
			MODE_EDGE: begin
				hold_left = click_hold;
				n_edge++;
			end
			MODE_READ: begin
				n_read++;
				if (rd_ptr != wr_ptr) begin
					res.sample = spk_en ? ring_mem[rd_ptr] : '0;
					res.sample_present = 1'b1;
					rd_ptr = ring_next(rd_ptr);
					if (!spk_en)
						n_muted++;
				end else begin
					// empty ring still answers, with nothing present
					res = '0;
					n_empty++;
				end
				expected_samples.push_back(res);
			end
		endcase
	endfunction

	function automatic int draw_gap();
		return calm_run ? 0 : int'($urandom_range(0, 4));
	endfunction

	// ---------------------------------------------------------------------------------------
	// driver: offers queued items, updates the predictor on every accepted one
	// ---------------------------------------------------------------------------------------

	int gap_left = 0;

	always @(posedge clk) begin
		int gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				playback_step(in_item);
			// a stalled item stays on the bus untouched
			if (!in_valid || !in_stall) begin
				gap = in_valid ? draw_gap() : gap_left;
				if (gap == 0 && queued_items.size() != 0) begin
					in_item  <= queued_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					gap_left <= (gap > 0) ? gap - 1 : 0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// monitor: random stall per result, plus one long hold-off on request
	// ---------------------------------------------------------------------------------------

	int stall_left = 0;
	int hold_seen  = 0;

	always @(posedge clk) begin
		out_item_t want;
		int n;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (expected_samples.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected sample %0d present %0b, nothing was due",
							out_item.sample, out_item.sample_present);
				end else begin
					want = expected_samples.pop_front();
					if (out_item.sample !== want.sample
						|| out_item.sample_present !== want.sample_present) begin
						errors++;
						if (errors <= 10)
							$display("sample mismatch: expected %0d present %0b, got %0d present %0b",
								want.sample, want.sample_present,
								out_item.sample, out_item.sample_present);
					end
				end
			end
			if (hold_ticket != hold_seen) begin
				// long hold-off so the block backs up and stalls its input
				hold_seen  <= hold_ticket;
				stall_left <= LONG_HOLD - 1;
				out_stall  <= 1'b1;
			end else if (out_valid && !out_stall) begin
				n = draw_gap();
				stall_left <= (n > 0) ? n - 1 : 0;
				out_stall  <= (n > 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// watchdog: only cycles in which no item moves on either side are counted
	// ---------------------------------------------------------------------------------------

	int stuck = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("no item moved for %0d cycles, %0d samples still due",
				stuck, expected_samples.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------------------------

	task automatic add_item(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] b, logic active,
		logic [TONE_W-1:0] tone);
		in_item_t it;
		it.mode          = mode;
		it.alaw_byte     = b;
		it.buzzer_active = active;
		it.tone_hz       = tone;
		queued_items.push_back(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	// only called with the block idle, so the shadow can follow at once
	task automatic set_registers(logic spk, logic [CLICK_W-1:0] hz, logic [HOLD_W-1:0] hold);
		write_reg(CFG_SPEAKER_ENABLED, CFG_DATA_W'(spk));
		write_reg(CFG_CLICK_TONE_HZ, CFG_DATA_W'(hz));
		write_reg(CFG_CLICK_HOLD_TICKS, CFG_DATA_W'(hold));
		@(posedge clk);
		cfg_we     <= 1'b0;
		spk_en     = spk;
		click_hz   = int'(hz);
		click_hold = int'(hold);
		n_settings++;
	endtask

	// wait until every item is taken and answered, then let trailing ticks finish
	task automatic drain();
		do
			@(negedge clk);
		while (queued_items.size() != 0 || in_valid || expected_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic fill_random(int count, int tick_pct);
		in_item_t it;
		int r;
		int t;
		for (int i = 0; i < count; i++) begin
			it = in_item_t'($urandom);
			r = $urandom_range(0, 99);
			if (r < tick_pct)
				it.mode = MODE_TICK;
			else if (r < tick_pct + 8)
				it.mode = MODE_EDGE;
			else if (r < tick_pct + 45)
				it.mode = MODE_PUSH;
			else
				it.mode = MODE_READ;
			// tones: click, low, clamped, top of the field
			t = $urandom_range(0, 9);
			case (t)
				0, 1: it.tone_hz = '0;
				2: it.tone_hz = TONE_W'(8000);
				3: it.tone_hz = '1;
				4, 5: it.tone_hz = TONE_W'($urandom_range(1, 400));
				default: it.tone_hz = TONE_W'($urandom_range(1, 8191));
			endcase
			queued_items.push_back(it);
		end
	endtask

	task automatic run_phase(logic spk, logic [CLICK_W-1:0] hz, logic [HOLD_W-1:0] hold,
		int tick_pct, bit long_hold, bit calm);
		set_registers(spk, hz, hold);
		@(negedge clk);
		calm_run = calm;
		if (long_hold) begin
			hold_ticket++;
			// a run of reads piles up behind the held output
			repeat (12)
				add_item(MODE_READ, BYTE_W'($urandom), 1'($urandom), TONE_W'($urandom));
		end
		fill_random(PHASE_ITEMS, tick_pct);
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		set_registers(SPEAKER_RST, CLICK_RST, HOLD_RST);
		@(negedge clk);

		// read from an empty ring
		add_item(MODE_READ, 8'h00, 1'b0, '0);
		// smallest, middle and largest magnitudes of both signs
		add_item(MODE_PUSH, 8'h55, 1'b1, '1);
		add_item(MODE_PUSH, 8'hd5, 1'b0, '0);
		add_item(MODE_PUSH, 8'h00, 1'b1, '1);
		add_item(MODE_PUSH, 8'hff, 1'b0, '0);
		add_item(MODE_PUSH, 8'h2a, 1'b1, '1);
		add_item(MODE_PUSH, 8'haa, 1'b0, '0);
		repeat (7)
			add_item(MODE_READ, 8'hff, 1'b1, '1);
		// closed gate gives a single silent sample
		add_item(MODE_TICK, 8'h00, 1'b0, TONE_W'(1000));
		add_item(MODE_READ, 8'h00, 1'b0, '0);
		// edge keeps the gate open for two ticks, then it closes
		add_item(MODE_EDGE, 8'h00, 1'b0, '0);
		add_item(MODE_TICK, 8'h00, 1'b0, TONE_W'(8000));
		add_item(MODE_TICK, 8'h00, 1'b0, '0);
		add_item(MODE_TICK, 8'h00, 1'b0, TONE_W'(1000));
		// long period, then a short one entered with the phase far past it
		add_item(MODE_TICK, 8'h00, 1'b1, TONE_W'(1));
		add_item(MODE_TICK, 8'h00, 1'b1, '1);
		repeat (3)
			add_item(MODE_READ, 8'h00, 1'b0, '0);
		drain();

		run_phase(1'b1, 12'd1000, 8'd2, 10, 1'b0, 1'b0);
		run_phase(1'b0, 12'd4000, 8'd255, 10, 1'b1, 1'b0);
		// few ticks, so the ring runs dry now and then
		run_phase(1'b1, 12'd1, 8'd0, 2, 1'b0, 1'b0);
		// zero click tone falls back to the lowest tone
		run_phase(1'b1, 12'd0, 8'd1, 15, 1'b0, 1'b0);
		run_phase(1'b0, 12'hfff, 8'd3, 8, 1'b0, 1'b1);
		run_phase(1'b1, CLICK_W'($urandom), HOLD_W'($urandom), 10, 1'b0, 1'b0);

		$display("%0d pushes, %0d ticks, %0d edges, %0d reads (%0d empty, %0d muted)",
			n_push, n_tick, n_edge, n_read, n_empty, n_muted);
		$display("%0d samples checked over %0d register settings, %0d overwritten in a full ring",
			n_checked, n_settings, n_dropped);
		if (errors == 0 && expected_samples.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
